@@ hw/rtl/jse_pkg.sv @@
// jse_pkg: shared types and character constants for the json string escaper
// no dependencies; used by json_string_escaper and jse_serializer
package jse_pkg;

    typedef logic [7:0] byte_t;

    // expanded output bytes of one item, packed lowest position first
    typedef struct packed {
        logic [7:0][7:0] bytes;
        logic [2:0]      last_idx;
    } jse_item_t;

    localparam byte_t CHAR_QUOTE     = 8'h22;
    localparam byte_t CHAR_BACKSLASH = 8'h5C;
    localparam byte_t CHAR_SLASH     = 8'h2F;
    localparam byte_t CHAR_U         = 8'h75;
    localparam byte_t CHAR_ZERO      = 8'h30;
    localparam byte_t CTRL_LIMIT     = 8'd32;

    localparam byte_t CODE_BS = 8'h08;
    localparam byte_t CODE_FF = 8'h0C;
    localparam byte_t CODE_LF = 8'h0A;
    localparam byte_t CODE_CR = 8'h0D;
    localparam byte_t CODE_HT = 8'h09;

    localparam byte_t HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

endpackage

@@ hw/rtl/jse_serializer.sv @@
// jse_serializer: emits the expanded bytes of one item, one byte per cycle while out_ready is high
// depends on jse_pkg
module jse_serializer
    import jse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  jse_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output byte_t     out_data,
    output logic      out_last
);

    logic            busy_reg, busy_next;
    logic [2:0]      idx_reg, idx_next;
    logic [7:0][7:0] bytes_reg;
    logic [2:0]      last_idx_reg;
    logic            at_end;
    logic            load;

    // output view of the current byte
    assign at_end    = (idx_reg == last_idx_reg);
    assign out_valid = busy_reg;
    assign out_data  = bytes_reg[idx_reg];
    assign out_last  = at_end;

    // take a new item when empty or when the final byte leaves now
    assign in_ready = !busy_reg || (out_ready && at_end);
    assign load     = in_valid && in_ready;

    // next busy flag and byte index
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = 3'd0;
        end
        else if (busy_reg && out_ready)
        begin
            if (at_end)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg    <= in_item.bytes;
            last_idx_reg <= in_item.last_idx;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg <= last_idx_reg))
        else $error("serializer index past last byte");

    a_idx_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_last) |=>
            (out_valid && idx_reg == $past(idx_reg) + 3'd1))
        else $error("serializer skipped or repeated a byte");
`endif

endmodule

@@ hw/rtl/json_string_escaper.sv @@
// json_string_escaper: three register stages then a byte serializer; an accepted input
// passes stage 1, stage 2, stage 3 and the serializer register before its first output byte.
// one input item per cycle when each item gives one byte and m_axis_tready stays high; an
// item that expands to more than one byte holds the serializer until its final byte leaves.
// rst_n is asynchronous, active low, and empties every stage; data regs keep no reset.
// depends on jse_pkg and jse_serializer
module json_string_escaper
    import jse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
    input  logic [1:0] s_axis_tuser,  // [0] first_byte, [1] empty_string
    input  logic       s_axis_tlast,  // last_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [7:0] out_byte
    output logic       m_axis_tlast   // out_last
);

    // stage valids and ready chain
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;
    logic ser_ready;

    // stage 1: raw input
    byte_t s1_byte_reg;
    logic  s1_first_reg, s1_last_reg, s1_empty_reg;

    // stage 2: escape body
    logic [7:0][7:0] s2_body_reg, s2_body_next;
    logic [2:0]      s2_len_reg, s2_len_next;
    logic            s2_first_reg, s2_last_reg;

    // stage 3: placed output bytes
    jse_item_t s3_item_reg, s3_item_next;

    assign rdy3          = !v3_reg || ser_ready;
    assign rdy2          = !v2_reg || rdy3;
    assign rdy1          = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;

    // short escape letter for the five named control codes, zero when none
    function automatic byte_t short_escape(input byte_t c);
        byte_t r;
        r = 8'h00;
        unique case (c)
            CODE_BS: r = 8'h62;
            CODE_FF: r = 8'h66;
            CODE_LF: r = 8'h6E;
            CODE_CR: r = 8'h72;
            CODE_HT: r = 8'h74;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // classify the byte and build its escaped body; an empty string becomes
    // an opening quote followed by a one-quote body
    always_comb
    begin
        byte_t sc;
        sc           = short_escape(s1_byte_reg);
        s2_body_next = '0;
        s2_len_next  = 3'd1;
        s2_body_next[0] = s1_byte_reg;
        priority if (s1_empty_reg)
        begin
            s2_body_next[0] = CHAR_QUOTE;
        end
        else if (s1_byte_reg == CHAR_QUOTE || s1_byte_reg == CHAR_BACKSLASH ||
                 s1_byte_reg == CHAR_SLASH)
        begin
            s2_body_next[0] = CHAR_BACKSLASH;
            s2_body_next[1] = s1_byte_reg;
            s2_len_next     = 3'd2;
        end
        else if (sc != 8'h00)
        begin
            s2_body_next[0] = CHAR_BACKSLASH;
            s2_body_next[1] = sc;
            s2_len_next     = 3'd2;
        end
        else if (s1_byte_reg < CTRL_LIMIT)
        begin
            s2_body_next[0] = CHAR_BACKSLASH;
            s2_body_next[1] = CHAR_U;
            s2_body_next[2] = CHAR_ZERO;
            s2_body_next[3] = CHAR_ZERO;
            s2_body_next[4] = HEX_DIGITS[s1_byte_reg[7:4]];
            s2_body_next[5] = HEX_DIGITS[s1_byte_reg[3:0]];
            s2_len_next     = 3'd6;
        end
        else
        begin
            s2_body_next[0] = s1_byte_reg;
        end
    end

    // place quotes around the body in the eight-byte output slot
    always_comb
    begin
        logic [3:0] j;
        logic [3:0] total;
        s3_item_next = '0;
        for (int i = 0; i < 8; i++)
        begin
            j = 4'(i) - {3'd0, s2_first_reg};
            if (s2_first_reg && i == 0)
            begin
                s3_item_next.bytes[i] = CHAR_QUOTE;
            end
            else if (j < {1'b0, s2_len_reg})
            begin
                s3_item_next.bytes[i] = s2_body_reg[j[2:0]];
            end
            else
            begin
                s3_item_next.bytes[i] = CHAR_QUOTE;
            end
        end
        total = {3'd0, s2_first_reg} + {1'b0, s2_len_reg} + {3'd0, s2_last_reg} - 4'd1;
        s3_item_next.last_idx = total[2:0];
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (rdy1 && s_axis_tvalid)
        begin
            s1_byte_reg  <= s_axis_tdata;
            s1_first_reg <= s_axis_tuser[0];
            s1_empty_reg <= s_axis_tuser[1];
            s1_last_reg  <= s_axis_tlast;
        end
        if (rdy2 && v1_reg)
        begin
            s2_body_reg  <= s2_body_next;
            s2_len_reg   <= s2_len_next;
            s2_first_reg <= s1_first_reg || s1_empty_reg;
            s2_last_reg  <= s1_last_reg && !s1_empty_reg;
        end
        if (rdy3 && v2_reg)
        begin
            s3_item_reg <= s3_item_next;
        end
    end

    // output serializer
    jse_serializer u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .in_ready  (ser_ready),
        .in_item   (s3_item_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_body_len: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (s2_len_reg == 3'd1 || s2_len_reg == 3'd2 || s2_len_reg == 3'd6))
        else $error("escape body has an impossible length");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (v1_reg && v2_reg && v3_reg && m_axis_tvalid))
        else $error("input stalled while a stage is free");
`endif

endmodule

@@ tb/tb_top.sv @@
// tb_top: self-checking stream testbench for json_string_escaper
// an in-line escaper predictor feeds a queue of expected output bytes, with random
// idling on both sides; depends on jse_pkg and the json_string_escaper rtl
module tb_top;
    import jse_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // letters of the short escapes and the first hex letter
    localparam byte_t CHAR_LOWER_A = 8'h61;
    localparam byte_t ESC_B        = 8'h62;
    localparam byte_t ESC_F        = 8'h66;
    localparam byte_t ESC_N        = 8'h6E;
    localparam byte_t ESC_R        = 8'h72;
    localparam byte_t ESC_T        = 8'h74;

    typedef struct {
        byte_t       data;
        logic        first;
        logic        last;
        logic        empty;
        int unsigned gap;
    } string_item_t;

    typedef struct {
        byte_t data;
        logic  last;
    } escaped_byte_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] in_byte
    logic [1:0] s_axis_tuser  = 2'b00;  // [0] first_byte, [1] empty_string
    logic       s_axis_tlast  = 1'b0;   // last_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic       m_axis_tlast;           // out_last

    string_item_t  pending_items[$];
    escaped_byte_t expected_escape[$];

    int unsigned n_total     = 0;
    int unsigned n_accepted  = 0;
    int unsigned n_results   = 0;
    int unsigned launch_wait = 0;
    int unsigned ready_stall = 0;
    logic        in_taken    = 1'b0;
    logic        out_taken   = 1'b0;
    bit          failed      = 1'b0;

    json_string_escaper u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    // hex digit of a nibble, lower case
    function automatic byte_t hex_char(logic [3:0] nib);
        if (nib < 4'd10)
            return CHAR_ZERO + byte_t'(nib);
        return CHAR_LOWER_A + byte_t'(nib) - 8'd10;
    endfunction

    // expected output bytes of one accepted item
    function automatic void predict_escape(byte_t c, logic first, logic last, logic empty);
        byte_t         seq[$];
        byte_t         short_code;
        escaped_byte_t eb;
        short_code = 8'h00;
        if (empty) begin
            seq.push_back(CHAR_QUOTE);
            seq.push_back(CHAR_QUOTE);
        end
        else begin
            if (first)
                seq.push_back(CHAR_QUOTE);
            case (c)
                CODE_BS: short_code = ESC_B;
                CODE_FF: short_code = ESC_F;
                CODE_LF: short_code = ESC_N;
                CODE_CR: short_code = ESC_R;
                CODE_HT: short_code = ESC_T;
                default: short_code = 8'h00;
            endcase
            if (c == CHAR_QUOTE || c == CHAR_BACKSLASH || c == CHAR_SLASH) begin
                seq.push_back(CHAR_BACKSLASH);
                seq.push_back(c);
            end
            else if (short_code != 8'h00) begin
                seq.push_back(CHAR_BACKSLASH);
                seq.push_back(short_code);
            end
            else if (c < CTRL_LIMIT) begin
                seq.push_back(CHAR_BACKSLASH);
                seq.push_back(CHAR_U);
                seq.push_back(CHAR_ZERO);
                seq.push_back(CHAR_ZERO);
                seq.push_back(hex_char(c[7:4]));
                seq.push_back(hex_char(c[3:0]));
            end
            else
                seq.push_back(c);
            if (last)
                seq.push_back(CHAR_QUOTE);
        end
        foreach (seq[i])
        begin
            eb.data = seq[i];
            eb.last = (i == seq.size() - 1);
            expected_escape.push_back(eb);
        end
    endfunction

    // queue one item; every third run of 40 items goes without sender gaps
    task automatic add_item(byte_t c, logic first, logic last, logic empty);
        string_item_t it;
        it.data  = c;
        it.first = first;
        it.last  = last;
        it.empty = empty;
        it.gap   = ((n_total / 40) % 3 == 2) ? 0 : $urandom_range(0, 9);
        pending_items.push_back(it);
        n_total++;
    endtask

    // random string byte, weighted toward the escaped classes
    function automatic byte_t pick_char();
        case ($urandom_range(0, 4))
            0: return byte_t'($urandom_range(0, 31));
            1:
            begin
                case ($urandom_range(0, 2))
                    0: return CHAR_QUOTE;
                    1: return CHAR_BACKSLASH;
                    default: return CHAR_SLASH;
                endcase
            end
            2: return byte_t'($urandom_range(32, 126));
            default: return byte_t'($urandom_range(0, 255));
        endcase
    endfunction

    // input driver: presents the next item after its gap, holds it until taken
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!(s_axis_tvalid && !in_taken)) begin
            if (pending_items.size() == 0)
                s_axis_tvalid <= 1'b0;
            else if (launch_wait < pending_items[0].gap) begin
                s_axis_tvalid <= 1'b0;
                launch_wait++;
            end
            else begin
                s_axis_tdata  <= pending_items[0].data;
                s_axis_tuser  <= {pending_items[0].empty, pending_items[0].first};
                s_axis_tlast  <= pending_items[0].last;
                s_axis_tvalid <= 1'b1;
                launch_wait = 0;
                void'(pending_items.pop_front());
            end
        end
    end

    // input side: predict each accepted item
    always @(posedge clk)
    begin
        in_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_escape(s_axis_tdata, s_axis_tuser[0], s_axis_tlast, s_axis_tuser[1]);
            n_accepted++;
        end
    end

    // output ready: stall after each byte taken, none in every third run of 50
    always @(negedge clk)
    begin
        if (out_taken)
            ready_stall = ((n_results / 50) % 3 == 2) ? 0 : $urandom_range(0, 9);
        if (ready_stall > 0) begin
            m_axis_tready <= 1'b0;
            ready_stall--;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // output monitor: compare each output byte with the oldest expectation
    always @(posedge clk)
    begin
        out_taken <= rst_n && m_axis_tvalid && m_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (expected_escape.size() == 0) begin
                $error("unexpected item: out_byte %h out_last %b", m_axis_tdata, m_axis_tlast);
                failed = 1'b1;
            end
            else begin
                if (m_axis_tdata !== expected_escape[0].data) begin
                    $error("out_byte: expected %h, got %h", expected_escape[0].data, m_axis_tdata);
                    failed = 1'b1;
                end
                if (m_axis_tlast !== expected_escape[0].last) begin
                    $error("out_last: expected %b, got %b", expected_escape[0].last, m_axis_tlast);
                    failed = 1'b1;
                end
                void'(expected_escape.pop_front());
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int unsigned len;
        // empty strings, marks ignored
        add_item(8'hFF, 1'b1, 1'b1, 1'b1);
        add_item(8'h00, 1'b0, 1'b0, 1'b1);
        // one-byte strings over the edges of each class
        add_item(8'h00, 1'b1, 1'b1, 1'b0);
        add_item(8'h1F, 1'b1, 1'b1, 1'b0);
        add_item(8'h20, 1'b1, 1'b1, 1'b0);
        add_item(CHAR_QUOTE, 1'b1, 1'b1, 1'b0);
        add_item(CHAR_BACKSLASH, 1'b1, 1'b1, 1'b0);
        add_item(CHAR_SLASH, 1'b1, 1'b1, 1'b0);
        add_item(CODE_BS, 1'b1, 1'b1, 1'b0);
        add_item(CODE_FF, 1'b1, 1'b1, 1'b0);
        add_item(CODE_LF, 1'b1, 1'b1, 1'b0);
        add_item(CODE_CR, 1'b1, 1'b1, 1'b0);
        add_item(CODE_HT, 1'b1, 1'b1, 1'b0);
        add_item(8'h7F, 1'b1, 1'b1, 1'b0);
        add_item(8'h80, 1'b1, 1'b1, 1'b0);
        add_item(8'hFF, 1'b1, 1'b1, 1'b0);
        // three-byte string with a middle byte and no marks
        add_item(8'h41, 1'b1, 1'b0, 1'b0);
        add_item(8'h1B, 1'b0, 1'b0, 1'b0);
        add_item(8'h7A, 1'b0, 1'b1, 1'b0);
        // marks out of order
        add_item(8'h5A, 1'b0, 1'b1, 1'b0);
        add_item(8'h01, 1'b1, 1'b0, 1'b0);

        // random part: mostly well-formed strings, some loose items
        while (n_total < 230) begin
            if ($urandom_range(0, 6) == 0) begin
                add_item(byte_t'($urandom_range(0, 255)), 1'($urandom), 1'($urandom),
                         1'($urandom_range(0, 3) == 0));
            end
            else if ($urandom_range(0, 9) == 0)
                add_item(byte_t'($urandom_range(0, 255)), 1'($urandom), 1'($urandom), 1'b1);
            else begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    add_item(pick_char(), i == 0, i == len - 1, 1'b0);
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (n_accepted < n_total)
            @(posedge clk);
        while (expected_escape.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (!failed && expected_escape.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
